[hdl/cism_pkg.sv]
// Package for the case-insensitive substring match block.
// Holds window sizing, register indexes, the cell control struct and byte folding.
// No dependencies.
package cism_pkg;

  localparam int KEY_MAX = 16;
  localparam int IDX_W   = $clog2(KEY_MAX);
  localparam int CNT_W   = $clog2(KEY_MAX + 1);

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

[hdl/cism_cell.sv]
// One window cell: holds one folded byte and compares its incoming byte with a key byte.
// Depends on cism_pkg.
module cism_cell
  import cism_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] shift_in,
  input  logic [7:0] key,
  input  logic       active,
  output logic [7:0] shift_out,
  output logic       eq
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'd0;
    end else if (ctrl.advance) begin
      held <= ctrl.clear ? 8'd0 : shift_in;
    end
  end

  assign shift_out = held;
  assign eq        = !active || (shift_in == key);

endmodule

[hdl/case_insensitive_substring_match.sv]
// Top level of the case-insensitive substring match block.
// Depends on cism_pkg and cism_cell (one cell per window byte).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | char_byte, last_char, end_of_list
//   out     | out       | out_valid/out_ready  | message_matched, any_matched, list_done
//
// One byte per cycle while in_ready is high; the cell row compares every window
// position in the cycle a byte is taken; a result is registered with its last byte.
// A two-entry output buffer lets input continue while one result waits; input
// stalls only when both entries are full. cfg_ready is always high.
// Synchronous reset clears the window, counters, match flags and output valid flags.
module case_insensitive_substring_match
  import cism_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  input  logic        end_of_list,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        message_matched,
  output logic        any_matched,
  output logic        list_done
);

  logic [63:0]      key_low;
  logic [63:0]      key_high;
  logic [4:0]       key_length;
  logic [CNT_W-1:0] bytes_seen;
  logic             message_hit;
  logic             list_hit;
  logic             skid_valid;
  logic [2:0]       main_res;
  logic [2:0]       skid_res;

  logic [7:0]       key_arr [16];
  logic [CNT_W-1:0] n;
  logic [7:0]       win [KEY_MAX];
  logic [7:0]       cin [KEY_MAX];
  logic [KEY_MAX-1:0] eqs;
  cell_ctrl_t       ctrl;
  logic             accept;
  logic             push;
  logic             pop;
  logic [CNT_W-1:0] bytes_seen_next;
  logic             msg_total;
  logic             any_total;
  logic [2:0]       new_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= 64'd0;
      key_high   <= 64'd0;
      key_length <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low    <= cfg_data;
        REG_KEY_HIGH: key_high   <= cfg_data;
        REG_KEY_LEN:  key_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      key_arr[k]     = fold_byte(key_low[8*k +: 8]);
      key_arr[k + 8] = fold_byte(key_high[8*k +: 8]);
    end
    if (key_length == 5'd0) begin
      n = CNT_W'(1);
    end else if (key_length > 5'(KEY_MAX)) begin
      n = CNT_W'(KEY_MAX);
    end else begin
      n = CNT_W'(key_length);
    end
  end

  assign accept       = in_valid && in_ready;
  assign ctrl.advance = accept;
  assign ctrl.clear   = last_char;

  genvar gi;
  generate
    for (gi = 0; gi < KEY_MAX; gi++) begin : g_cell
      logic [CNT_W-1:0] kidx;
      logic [IDX_W-1:0] ksel;
      assign kidx = n - CNT_W'(1) - CNT_W'(gi);
      assign ksel = kidx[IDX_W-1:0];
      if (gi == 0) begin : g_head
        assign cin[gi] = fold_byte(char_byte);
      end else begin : g_body
        assign cin[gi] = win[gi-1];
      end
      cism_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .shift_in (cin[gi]),
        .key      (key_arr[ksel]),
        .active   (CNT_W'(gi) < n),
        .shift_out(win[gi]),
        .eq       (eqs[gi])
      );
    end
  endgenerate

  assign bytes_seen_next = (bytes_seen < CNT_W'(KEY_MAX)) ? bytes_seen + CNT_W'(1) : bytes_seen;
  assign msg_total = message_hit || ((&eqs) && (bytes_seen_next >= n));
  assign any_total = list_hit || msg_total;
  assign new_res   = {msg_total, any_total, end_of_list};

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      message_hit <= 1'b0;
      list_hit    <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        bytes_seen  <= '0;
        message_hit <= 1'b0;
        list_hit    <= end_of_list ? 1'b0 : any_total;
      end else begin
        bytes_seen  <= bytes_seen_next;
        message_hit <= msg_total;
      end
    end
  end

  assign in_ready = !skid_valid;
  assign push     = accept && last_char;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid) begin
      if (push && !pop) begin
        skid_valid <= 1'b1;
      end else if (pop && !push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        main_res <= new_res;
      end else begin
        skid_res <= new_res;
      end
    end
  end

  assign message_matched = main_res[2];
  assign any_matched     = main_res[1];
  assign list_done       = main_res[0];

endmodule
